/* design/assert_macros.svh */
// assert_macros.svh: assertion helpers for the seed fill core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// label: property holds on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// label: property checked during reset too
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

/* design/grsf_pkg.sv */
// ----------------------------------------------------------------------------
// grsf_pkg: shared types and constants for the grid region seed fill core
// Command codes, register indexes, controller states, grid sizes and wrap helpers.
// ----------------------------------------------------------------------------
package grsf_pkg;
   localparam int MaxWidth  = 256;
   localparam int MaxHeight = 256;
   localparam int CellBits  = 8;
   localparam int XBits     = $clog2(MaxWidth);
   localparam int YBits     = $clog2(MaxHeight);
   localparam int AddrBits  = XBits + YBits;
   localparam int ExtBits   = 9;
   // signed working coordinate: covers -255..510
   localparam int CBits     = 11;

   typedef logic [1:0] cmd_type;
   localparam cmd_type CmdSeed  = 2'd0;
   localparam cmd_type CmdClear = 2'd1;
   localparam cmd_type CmdRead  = 2'd2;

   typedef logic [1:0] csr_index_type;
   localparam csr_index_type RegWidth  = 2'd0;
   localparam csr_index_type RegHeight = 2'd1;
   localparam csr_index_type RegSeed   = 2'd2;

   typedef enum logic [2:0] {
      StIdle, StClear, StSquare, StRing, StRead, StDone, StInit, StWrap
   } state_type;

   typedef struct packed {
      logic                wr_en;
      logic [AddrBits-1:0] wr_addr;
      logic [CellBits-1:0] wr_data;
      logic                rd_en;
      logic [AddrBits-1:0] rd_addr;
   } mem_req_type;

   // reduce a coordinate within -n..2n-1 into 0..n-1
   function automatic logic [ExtBits-1:0] wrap_c(input logic signed [CBits-1:0] c,
                                                 input logic [ExtBits-1:0] n);
      logic signed [CBits-1:0] ns;
      logic signed [CBits-1:0] m;
      begin
         ns = $signed({2'b00, n});
         m = c;
         if (m < 0) m = m + ns;
         if (m >= ns) m = m - ns;
         wrap_c = m[ExtBits-1:0];
      end
   endfunction
endpackage

/* design/grid_region_seed_fill_core.sv */
// ----------------------------------------------------------------------------
// grid_region_seed_fill_core: cell grid with seed, clear and read commands
// Seeds squares or midpoint circle rings, clipped or wrapped, into a grid.
// ----------------------------------------------------------------------------
//  channel   ports                              handshake
//  request   req_cmd .. req_clip_edges          start & !busy
//  result    rsp_read_value, rsp_done_cmd       done strobe, one cycle
//  config    csr_wr_en, csr_index, csr_wr_data  csr_wr_en
// Square seed: visits the (2r+1)^2 span, fewer points when a wrapped span covers an axis.
// Circle seed: eight points per octant step over all rings. A wrapped point more
// than one extent outside the grid holds the walk while its coordinates are reduced.
// Reset zeroes all 65536 cells, one per cycle, with busy held high.
// Results cannot be stalled; done is a one-cycle strobe.
module grid_region_seed_fill_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_pos_x,
   input  logic [7:0]  req_pos_y,
   input  logic [7:0]  req_radius,
   input  logic        req_round_shape,
   input  logic        req_clip_edges,
   output logic        done,
   output logic [7:0]  rsp_read_value,
   output logic [1:0]  rsp_done_cmd,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_wr_data
);
   logic [8:0] width_ff, height_ff;
   logic [7:0] seed_ff;
   logic [8:0] ext_w, ext_h;
   grsf_pkg::mem_req_type mem_req;
   logic [7:0] rd_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 9'd256; height_ff <= 9'd256; seed_ff <= 8'd1;
      end else if (csr_wr_en) begin
         case (csr_index)
            grsf_pkg::RegWidth:  width_ff <= csr_wr_data;
            grsf_pkg::RegHeight: height_ff <= csr_wr_data;
            grsf_pkg::RegSeed:   seed_ff <= csr_wr_data[7:0];
            default:   ;
         endcase
      end
   end

   // clamp extents into 1..max
   assign ext_w = (width_ff == 9'd0) ? 9'd1 : (width_ff > 9'd256) ? 9'd256 : width_ff;
   assign ext_h = (height_ff == 9'd0) ? 9'd1 : (height_ff > 9'd256) ? 9'd256 : height_ff;

   grsf_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .cmd(req_cmd), .pos_x(req_pos_x), .pos_y(req_pos_y), .radius(req_radius),
      .round_shape(req_round_shape), .clip_edges(req_clip_edges),
      .ext_w(ext_w), .ext_h(ext_h), .seed(seed_ff),
      .mem_req(mem_req), .rd_data(rd_data),
      .done(done), .read_value(rsp_read_value), .done_cmd(rsp_done_cmd)
   );

   grsf_grid_mem u_mem (.clock(clock), .mem_req(mem_req), .rd_data(rd_data));
endmodule

/* design/grsf_grid_mem.sv */
// ----------------------------------------------------------------------------
// grsf_grid_mem: cell grid store
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module grsf_grid_mem (
   input  logic                               clock,
   input  grsf_pkg::mem_req_type              mem_req,
   output logic [grsf_pkg::CellBits-1:0]      rd_data
);
   logic [grsf_pkg::CellBits-1:0] mem [0:(1 << grsf_pkg::AddrBits)-1];
   logic [grsf_pkg::CellBits-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) mem[mem_req.wr_addr] <= mem_req.wr_data;
      if (mem_req.rd_en) rd_data_ff <= mem[mem_req.rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

/* design/grsf_ctrl.sv */
// ----------------------------------------------------------------------------
// grsf_ctrl: command sequencer
// Walks square spans, midpoint rings, clear sweeps and reads; one cell a cycle,
// longer for wrapped points far outside the grid.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module grsf_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  grsf_pkg::cmd_type               cmd,
   input  logic [7:0]                      pos_x,
   input  logic [7:0]                      pos_y,
   input  logic [7:0]                      radius,
   input  logic                            round_shape,
   input  logic                            clip_edges,
   input  logic [grsf_pkg::ExtBits-1:0]    ext_w,
   input  logic [grsf_pkg::ExtBits-1:0]    ext_h,
   input  logic [grsf_pkg::CellBits-1:0]   seed,
   output grsf_pkg::mem_req_type           mem_req,
   input  logic [grsf_pkg::CellBits-1:0]   rd_data,
   output logic                            done,
   output logic [7:0]                      read_value,
   output grsf_pkg::cmd_type               done_cmd
);
   localparam int CB = grsf_pkg::CBits;

   grsf_pkg::state_type state_ff, state_in;
   grsf_pkg::state_type ret_ff, ret_in;
   grsf_pkg::cmd_type cmd_ff, cmd_in;
   logic [7:0] x_ff, x_in, y_ff, y_in, r_ff, r_in;
   logic clip_ff, clip_in, rdok_ff, rdok_in;
   // square offsets, ring walker
   logic signed [CB-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [7:0] ring_ff, ring_in, px_ff, px_in, py_ff, py_in;
   logic signed [CB+1:0] d_ff, d_in;
   logic [2:0] oct_ff, oct_in;
   logic [grsf_pkg::AddrBits-1:0] clr_ff, clr_in;
   // coordinate reducer for wrapped points far outside the grid
   logic [9:0] rax_ff, rax_in, ray_ff, ray_in;
   logic [16:0] dvx_ff, dvx_in, dvy_ff, dvy_in;
   logic negx_ff, negx_in, negy_ff, negy_in;
   logic [3:0] red_cnt_ff, red_cnt_in;
   logic wrap_rdy_ff, wrap_rdy_in;

   logic signed [CB-1:0] ox, oy, cx, cy, rs, abs_cx, abs_cy;
   logic [grsf_pkg::ExtBits-1:0] wx, wy, fx, fy;
   logic in_grid, full_x, full_y, plot_en;
   logic walk, fast_x, fast_y, need_red;
   logic [7:0] px_nx;

   assign rs = $signed({3'b000, r_ff});
   // a span as wide as the axis fills the whole axis under wrap
   assign full_x = ({2'b00, r_ff, 1'b1} >= {2'b00, ext_w});
   assign full_y = ({2'b00, r_ff, 1'b1} >= {2'b00, ext_h});

   // select the offset of the current point
   always_comb begin
      ox = dx_ff;
      oy = dy_ff;
      if (state_ff == grsf_pkg::StRing) begin
         case (oct_ff)
            3'd0: begin ox =  $signed({3'b0, px_ff}); oy =  $signed({3'b0, py_ff}); end
            3'd1: begin ox = -$signed({3'b0, px_ff}); oy =  $signed({3'b0, py_ff}); end
            3'd2: begin ox =  $signed({3'b0, px_ff}); oy = -$signed({3'b0, py_ff}); end
            3'd3: begin ox = -$signed({3'b0, px_ff}); oy = -$signed({3'b0, py_ff}); end
            3'd4: begin ox =  $signed({3'b0, py_ff}); oy =  $signed({3'b0, px_ff}); end
            3'd5: begin ox = -$signed({3'b0, py_ff}); oy =  $signed({3'b0, px_ff}); end
            3'd6: begin ox =  $signed({3'b0, py_ff}); oy = -$signed({3'b0, px_ff}); end
            default: begin ox = -$signed({3'b0, py_ff}); oy = -$signed({3'b0, px_ff}); end
         endcase
      end
   end

   assign cx = $signed({3'b0, x_ff}) + ox;
   assign cy = $signed({3'b0, y_ff}) + oy;
   assign in_grid = (cx >= 0) && (cy >= 0) && (cx < $signed({2'b00, ext_w}))
                    && (cy < $signed({2'b00, ext_h}));
   assign wx = grsf_pkg::wrap_c(cx, ext_w);
   assign wy = grsf_pkg::wrap_c(cy, ext_h);
   assign px_nx = px_ff + 8'd1;

   // wrapped points outside -n..2n-1 go through the reducer before they are written
   assign walk = (state_ff == grsf_pkg::StSquare) || (state_ff == grsf_pkg::StRing);
   assign fast_x = (cx >= -$signed({2'b00, ext_w})) && (cx < $signed({1'b0, ext_w, 1'b0}));
   assign fast_y = (cy >= -$signed({2'b00, ext_h})) && (cy < $signed({1'b0, ext_h, 1'b0}));
   assign need_red = walk && !clip_ff && !wrap_rdy_ff && !(fast_x && fast_y);
   assign abs_cx = cx[CB-1] ? -cx : cx;
   assign abs_cy = cy[CB-1] ? -cy : cy;
   assign fx = negx_ff ? ((rax_ff == 10'd0) ? 9'd0 : ext_w - rax_ff[8:0]) : rax_ff[8:0];
   assign fy = negy_ff ? ((ray_ff == 10'd0) ? 9'd0 : ext_h - ray_ff[8:0]) : ray_ff[8:0];

   // state register; reset starts the sweep that zeroes the grid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= grsf_pkg::StInit;
         clr_ff <= '0;
         wrap_rdy_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         wrap_rdy_ff <= wrap_rdy_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in; x_ff <= x_in; y_ff <= y_in; r_ff <= r_in;
      clip_ff <= clip_in; rdok_ff <= rdok_in;
      dx_ff <= dx_in; dy_ff <= dy_in; ring_ff <= ring_in;
      px_ff <= px_in; py_ff <= py_in; d_ff <= d_in; oct_ff <= oct_in;
      ret_ff <= ret_in; rax_ff <= rax_in; ray_ff <= ray_in;
      dvx_ff <= dvx_in; dvy_ff <= dvy_in; negx_ff <= negx_in; negy_ff <= negy_in;
      red_cnt_ff <= red_cnt_in;
   end

   // next state, walker steps and memory requests
   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff; x_in = x_ff; y_in = y_ff; r_in = r_ff;
      clip_in = clip_ff; rdok_in = rdok_ff;
      dx_in = dx_ff; dy_in = dy_ff; ring_in = ring_ff;
      px_in = px_ff; py_in = py_ff; d_in = d_ff; oct_in = oct_ff;
      clr_in = clr_ff;
      ret_in = ret_ff; rax_in = rax_ff; ray_in = ray_ff;
      dvx_in = dvx_ff; dvy_in = dvy_ff; negx_in = negx_ff; negy_in = negy_ff;
      red_cnt_in = red_cnt_ff; wrap_rdy_in = wrap_rdy_ff;
      mem_req = '0;
      plot_en = 1'b0;
      done = 1'b0;
      read_value = '0;
      done_cmd = cmd_ff;
      busy = (state_ff != grsf_pkg::StIdle);
      case (state_ff)
         grsf_pkg::StIdle: begin
            if (start) begin
               cmd_in = cmd; x_in = pos_x; y_in = pos_y; r_in = radius;
               clip_in = clip_edges;
               dx_in = -$signed({3'b0, radius});
               dy_in = -$signed({3'b0, radius});
               ring_in = radius; px_in = '0; py_in = radius; oct_in = '0;
               d_in = $signed(13'sd3) - $signed({4'b0, radius, 1'b0});
               clr_in = '0;
               wrap_rdy_in = 1'b0;
               rdok_in = ({1'b0, pos_x} < ext_w) && ({1'b0, pos_y} < ext_h);
               case (cmd)
                  grsf_pkg::CmdSeed:
                     state_in = round_shape ? ((radius == 8'd0) ? grsf_pkg::StDone
                                                                 : grsf_pkg::StRing)
                                            : grsf_pkg::StSquare;
                  grsf_pkg::CmdClear: state_in = grsf_pkg::StClear;
                  grsf_pkg::CmdRead: begin
                     state_in = grsf_pkg::StRead;
                     mem_req.rd_en = 1'b1;
                     mem_req.rd_addr = {pos_y, pos_x};
                  end
                  default: state_in = grsf_pkg::StDone;
               endcase
            end
         end
         // zero the grid after reset, no result
         grsf_pkg::StInit: begin
            mem_req.wr_en = 1'b1;
            mem_req.wr_addr = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (&clr_ff) state_in = grsf_pkg::StIdle;
         end
         grsf_pkg::StClear: begin
            mem_req.wr_en = 1'b1;
            mem_req.wr_addr = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (&clr_ff) state_in = grsf_pkg::StDone;
         end
         grsf_pkg::StSquare: begin
            plot_en = 1'b1;
            if (!need_red) begin
               wrap_rdy_in = 1'b0;
               // skip the redundant part of a span that covers the axis
               if (dx_ff == rs || (!clip_ff && full_x && cx - $signed({2'b0, ext_w}) ==
                                   $signed({3'b0, x_ff}) - rs - 11'sd1)) begin
                  dx_in = -rs;
                  if (dy_ff == rs || (!clip_ff && full_y && cy - $signed({2'b0, ext_h}) ==
                                      $signed({3'b0, y_ff}) - rs - 11'sd1))
                     state_in = grsf_pkg::StDone;
                  else
                     dy_in = dy_ff + 11'sd1;
               end else begin
                  dx_in = dx_ff + 11'sd1;
               end
            end
         end
         grsf_pkg::StRing: begin
            plot_en = 1'b1;
            if (!need_red) begin
               wrap_rdy_in = 1'b0;
               oct_in = oct_ff + 3'd1;
               if (oct_ff == 3'd7) begin
                  if (d_ff < 0) begin
                     d_in = d_ff + $signed({3'b0, px_nx, 2'b00}) + 13'sd6;
                  end else begin
                     py_in = py_ff - 8'd1;
                     d_in = d_ff + $signed({3'b0, px_nx, 2'b00})
                            - $signed({3'b0, py_ff - 8'd1, 2'b00}) + 13'sd10;
                  end
                  px_in = px_nx;
                  // leave this ring once px passes py
                  if ((d_ff < 0) ? (px_nx > py_ff) : (px_nx > py_ff - 8'd1)) begin
                     if (ring_ff == 8'd1) state_in = grsf_pkg::StDone;
                     else begin
                        ring_in = ring_ff - 8'd1;
                        px_in = '0;
                        py_in = ring_ff - 8'd1;
                        d_in = $signed(13'sd3) - $signed({4'b0, ring_ff - 8'd1, 1'b0});
                     end
                  end
               end
            end
         end
         // reduce both magnitudes, one compare and subtract of n<<k a cycle
         grsf_pkg::StWrap: begin
            if ({7'b0, rax_ff} >= dvx_ff) rax_in = rax_ff - dvx_ff[9:0];
            if ({7'b0, ray_ff} >= dvy_ff) ray_in = ray_ff - dvy_ff[9:0];
            dvx_in = dvx_ff >> 1;
            dvy_in = dvy_ff >> 1;
            red_cnt_in = red_cnt_ff + 4'd1;
            if (red_cnt_ff == 4'd8) begin
               state_in = ret_ff;
               wrap_rdy_in = 1'b1;
            end
         end
         grsf_pkg::StRead: state_in = grsf_pkg::StDone;
         grsf_pkg::StDone: begin
            done = 1'b1;
            read_value = (cmd_ff == grsf_pkg::CmdRead && rdok_ff) ? rd_data : '0;
            state_in = grsf_pkg::StIdle;
         end
         default: state_in = grsf_pkg::StIdle;
      endcase
      // hold the walker and load the reducer for a far wrapped point
      if (need_red) begin
         state_in = grsf_pkg::StWrap;
         ret_in = state_ff;
         rax_in = abs_cx[9:0];
         ray_in = abs_cy[9:0];
         negx_in = cx[CB-1];
         negy_in = cy[CB-1];
         dvx_in = {ext_w, 8'h00};
         dvy_in = {ext_h, 8'h00};
         red_cnt_in = '0;
      end
      if (plot_en && !need_red && (!clip_ff || in_grid)) begin
         mem_req.wr_en = 1'b1;
         mem_req.wr_data = seed;
         mem_req.wr_addr = clip_ff ? {cy[7:0], cx[7:0]} :
                           wrap_rdy_ff ? {fy[7:0], fx[7:0]} : {wy[7:0], wx[7:0]};
      end
   end

   `ASSERT_CLK(a_done_idle, clock, reset, done |=> !busy, "done not followed by idle")
   `ASSERT_CLK(a_one_port, clock, reset, !(mem_req.rd_en && mem_req.wr_en),
               "read and write in one cycle")
   `ASSERT_CLK(a_start_busy, clock, reset, (start && !busy) |=> busy, "start not taken")
   `ASSERT_ALWAYS(a_reset_sweep, clock, reset |=> busy, "no grid sweep after reset")
endmodule

/* verif/tb_grid_region_seed_fill_core.sv */
// ----------------------------------------------------------------------------
// tb_grid_region_seed_fill_core: self-checking bench for the seed fill core
// Runs a directed table and then random commands across several grid setups.
// A local copy of the cell grid predicts each result, and every strobed
// result is compared in order with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_grid_region_seed_fill_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CmdUnused = 2'd3;

   typedef struct {
      logic [1:0] cmd;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] r;
      logic       rnd;
      logic       clip;
      bit         typed;
      logic [7:0] want_value;
   } cmd_row_type;

   typedef struct packed {
      logic [7:0] value;
      logic [1:0] cmd;
   } done_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [1:0] req_cmd = '0;
   logic [7:0] req_pos_x = '0;
   logic [7:0] req_pos_y = '0;
   logic [7:0] req_radius = '0;
   logic       req_round_shape = 1'b0;
   logic       req_clip_edges = 1'b0;
   logic       done;
   logic [7:0] rsp_read_value;
   logic [1:0] rsp_done_cmd;
   logic       csr_wr_en = 1'b0;
   logic [1:0] csr_index = '0;
   logic [8:0] csr_wr_data = '0;

   // local copy of the grid and registers
   logic [7:0] shadow_grid [0:65535];
   logic [8:0] cfg_width;
   logic [8:0] cfg_height;
   logic [7:0] cfg_seed;
   done_type   pending_done [$];
   int         n_errors = 0;

   grid_region_seed_fill_core u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_pos_x(req_pos_x), .req_pos_y(req_pos_y),
      .req_radius(req_radius), .req_round_shape(req_round_shape),
      .req_clip_edges(req_clip_edges), .done(done),
      .rsp_read_value(rsp_read_value), .rsp_done_cmd(rsp_done_cmd),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #500ms;
      $display("status: fail");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      n_errors++;
   endtask

   function automatic int extent_in_use(input logic [8:0] raw_val);
      if (raw_val == 0) return 1;
      if (raw_val > 256) return 256;
      return int'(raw_val);
   endfunction

   function automatic void plot_cell(input int cx, input int cy, input bit clip);
      int w;
      int h;
      w = extent_in_use(cfg_width);
      h = extent_in_use(cfg_height);
      if (clip) begin
         if (cx < 0 || cx >= w || cy < 0 || cy >= h) return;
      end else begin
         cx = cx % w;
         if (cx < 0) cx += w;
         cy = cy % h;
         if (cy < 0) cy += h;
      end
      shadow_grid[cy * 256 + cx] = cfg_seed;
   endfunction

   // apply one command to the local grid and return its result
   function automatic done_type apply_command(input cmd_row_type c);
      done_type res;
      int x;
      int y;
      int r;
      int px;
      int py;
      int d;
      x = int'(c.x);
      y = int'(c.y);
      r = int'(c.r);
      res.value = '0;
      res.cmd = c.cmd;
      case (c.cmd)
         grsf_pkg::CmdSeed: begin
            if (!c.rnd) begin
               for (int dy = -r; dy <= r; dy++)
                  for (int dx = -r; dx <= r; dx++)
                     plot_cell(x + dx, y + dy, c.clip);
            end else begin
               for (int ring = r; ring >= 1; ring--) begin
                  px = 0;
                  py = ring;
                  d = 3 - 2 * ring;
                  while (px <= py) begin
                     plot_cell(x + px, y + py, c.clip);
                     plot_cell(x - px, y + py, c.clip);
                     plot_cell(x + px, y - py, c.clip);
                     plot_cell(x - px, y - py, c.clip);
                     plot_cell(x + py, y + px, c.clip);
                     plot_cell(x - py, y + px, c.clip);
                     plot_cell(x + py, y - px, c.clip);
                     plot_cell(x - py, y - px, c.clip);
                     px++;
                     if (d < 0) begin
                        d += 4 * px + 6;
                     end else begin
                        py--;
                        d += 4 * (px - py) + 10;
                     end
                  end
               end
            end
         end
         grsf_pkg::CmdClear: begin
            foreach (shadow_grid[i]) shadow_grid[i] = '0;
         end
         grsf_pkg::CmdRead: begin
            if (x < extent_in_use(cfg_width) && y < extent_in_use(cfg_height))
               res.value = shadow_grid[y * 256 + x];
         end
         default: ;
      endcase
      return res;
   endfunction

   // hold the item until accepted, then record its result; leave start high
   task automatic issue_command(input cmd_row_type c);
      done_type res;
      start <= 1'b1;
      req_cmd <= c.cmd;
      req_pos_x <= c.x;
      req_pos_y <= c.y;
      req_radius <= c.r;
      req_round_shape <= c.rnd;
      req_clip_edges <= c.clip;
      do @(posedge clock); while (busy);
      res = apply_command(c);
      if (c.typed) res.value = c.want_value;
      pending_done.push_back(res);
   endtask

   // random gap: mostly none, some short, a few long
   task automatic sender_gap();
      int pick;
      int gap;
      pick = $urandom_range(0, 99);
      if (pick < 60) gap = 0;
      else if (pick < 92) gap = $urandom_range(1, 4);
      else gap = $urandom_range(20, 80);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // drain every result, then let the block settle
   task automatic drain_results();
      start <= 1'b0;
      while (pending_done.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [8:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      case (idx)
         grsf_pkg::RegWidth:  cfg_width = data;
         grsf_pkg::RegHeight: cfg_height = data;
         default:   cfg_seed = data[7:0];
      endcase
   endtask

   function automatic cmd_row_type random_command();
      cmd_row_type c;
      int pick;
      int w;
      int h;
      w = extent_in_use(cfg_width);
      h = extent_in_use(cfg_height);
      pick = $urandom_range(0, 999);
      if (pick < 4) c.cmd = grsf_pkg::CmdClear;
      else if (pick < 40) c.cmd = CmdUnused;
      else if (pick < 520) c.cmd = grsf_pkg::CmdSeed;
      else c.cmd = grsf_pkg::CmdRead;
      if ($urandom_range(0, 3) == 0) begin
         c.x = 8'($urandom_range(0, 255));
         c.y = 8'($urandom_range(0, 255));
      end else begin
         c.x = 8'($urandom_range(0, w - 1));
         c.y = 8'($urandom_range(0, h - 1));
      end
      pick = $urandom_range(0, 999);
      if (pick < 900) c.r = 8'($urandom_range(0, 7));
      else if (pick < 993) c.r = 8'($urandom_range(8, 40));
      else c.r = 8'($urandom_range(41, 255));
      c.rnd = 1'($urandom_range(0, 1));
      c.clip = 1'($urandom_range(0, 1));
      c.typed = 1'b0;
      c.want_value = '0;
      return c;
   endfunction

   // compare each strobed result with the oldest prediction
   always @(posedge clock) begin
      done_type want;
      if (!reset && done) begin
         if (pending_done.size() == 0) begin
            report_mismatch("result with nothing outstanding");
         end else begin
            want = pending_done.pop_front();
            if (rsp_done_cmd !== want.cmd)
               report_mismatch($sformatf("done_cmd %0d, expected %0d",
                                         rsp_done_cmd, want.cmd));
            if (rsp_read_value !== want.value)
               report_mismatch($sformatf("read_value %0d, expected %0d (cmd %0d)",
                                         rsp_read_value, want.value, want.cmd));
         end
      end
   end

   initial begin
      cmd_row_type directed [$];
      logic [8:0]  phase_cfg [7][3];
      int          wait_cycles;

      foreach (shadow_grid[i]) shadow_grid[i] = '0;
      cfg_width = 9'd256;
      cfg_height = 9'd256;
      cfg_seed = 8'd1;

      // clear first, then probe corners and the special cases
      directed = '{
         '{grsf_pkg::CmdClear, 8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 1'b1, 8'd0},
         '{grsf_pkg::CmdRead,  8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 1'b1, 8'd0},
         '{grsf_pkg::CmdRead,  8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 1'b1, 8'd0},
         '{CmdUnused,          8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 1'b1, 8'd0},
         '{grsf_pkg::CmdSeed,  8'd0,   8'd0,   8'd0,   1'b0, 1'b1, 1'b0, 8'd0},
         '{grsf_pkg::CmdRead,  8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 1'b0, 8'd0},
         '{grsf_pkg::CmdSeed,  8'd255, 8'd255, 8'd1,   1'b0, 1'b1, 1'b0, 8'd0},
         '{grsf_pkg::CmdRead,  8'd254, 8'd254, 8'd0,   1'b0, 1'b0, 1'b0, 8'd0},
         '{grsf_pkg::CmdSeed,  8'd0,   8'd0,   8'd2,   1'b0, 1'b0, 1'b0, 8'd0},
         '{grsf_pkg::CmdRead,  8'd254, 8'd255, 8'd0,   1'b0, 1'b0, 1'b0, 8'd0},
         '{grsf_pkg::CmdSeed,  8'd10,  8'd10,  8'd3,   1'b1, 1'b1, 1'b0, 8'd0},
         '{grsf_pkg::CmdRead,  8'd10,  8'd13,  8'd0,   1'b0, 1'b0, 1'b0, 8'd0},
         '{grsf_pkg::CmdRead,  8'd10,  8'd10,  8'd0,   1'b0, 1'b0, 1'b0, 8'd0},
         '{grsf_pkg::CmdSeed,  8'd1,   8'd1,   8'd4,   1'b1, 1'b0, 1'b0, 8'd0},
         '{grsf_pkg::CmdRead,  8'd253, 8'd1,   8'd0,   1'b0, 1'b0, 1'b0, 8'd0},
         '{grsf_pkg::CmdSeed,  8'd128, 8'd128, 8'd255, 1'b1, 1'b1, 1'b0, 8'd0},
         '{grsf_pkg::CmdRead,  8'd128, 8'd1,   8'd0,   1'b0, 1'b0, 1'b0, 8'd0},
         '{grsf_pkg::CmdRead,  8'd128, 8'd128, 8'd0,   1'b0, 1'b0, 1'b0, 8'd0},
         '{grsf_pkg::CmdClear, 8'd17,  8'd34,  8'd51,  1'b1, 1'b0, 1'b1, 8'd0},
         '{grsf_pkg::CmdRead,  8'd128, 8'd1,   8'd0,   1'b0, 1'b0, 1'b1, 8'd0}
      };

      // width, height, seed per random phase, extremes included
      phase_cfg = '{
         '{9'd256, 9'd256, 9'd1},   '{9'd1,   9'd1,   9'd255},
         '{9'd0,   9'd0,   9'd0},   '{9'd511, 9'd511, 9'd170},
         '{9'd5,   9'd7,   9'd341}, '{9'd300, 9'd2,   9'd3},
         '{9'd40,  9'd33,  9'd85}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the directed table
      foreach (directed[i]) begin
         issue_command(directed[i]);
         sender_gap();
      end
      drain_results();

      // random phases, each behind a fresh register setup
      for (int p = 0; p < 7; p++) begin
         write_csr(grsf_pkg::RegWidth, phase_cfg[p][0]);
         write_csr(grsf_pkg::RegHeight, phase_cfg[p][1]);
         write_csr(grsf_pkg::RegSeed, phase_cfg[p][2]);
         csr_wr_en <= 1'b0;
         @(posedge clock);
         for (int k = 0; k < 80; k++) begin
            issue_command(random_command());
            if (p % 3 != 1) sender_gap();
         end
         drain_results();
      end

      wait_cycles = 0;
      while (pending_done.size() != 0 && wait_cycles < 400000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (10) @(posedge clock);
      if (n_errors == 0 && pending_done.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
